FILE: sv/ppp_pkg.sv
package ppp_pkg;
  localparam int unsigned AddrW     = 4;
  localparam int unsigned DivStages = 64;
  localparam int unsigned QW        = 64;

  localparam logic [AddrW-1:0] ADDR_FOCAL_X  = 4'h0;
  localparam logic [AddrW-1:0] ADDR_FOCAL_Y  = 4'h4;
  localparam logic [AddrW-1:0] ADDR_CENTER_X = 4'h8;
  localparam logic [AddrW-1:0] ADDR_CENTER_Y = 4'hC;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic [31:0] focal_x;
    logic [31:0] focal_y;
    logic [31:0] center_x;
    logic [31:0] center_y;
  } cfg_regs_t;

  // per-axis work carried through the divider pipeline
  typedef struct packed {
    logic [QW-1:0]   rem;
    logic [QW-1:0]   quo;
    logic            neg;
    logic [31:0]     ctr;
  } axis_t;
endpackage

FILE: sv/ppp_if.sv
interface ppp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [31:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ppp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_u;
  logic [31:0] pixel_v;
  logic [1:0]  status;
  modport source (output valid, pixel_u, pixel_v, status, input ready);
  modport sink (input valid, pixel_u, pixel_v, status, output ready);
endinterface

FILE: sv/ppp_cfg.sv
module ppp_cfg
  import ppp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [AddrW-1:0] cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output cfg_regs_t        regs
);
  cfg_regs_t regs_r;
  logic      wr;

  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign regs       = regs_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.focal_x  <= 32'h0001_0000;
      regs_r.focal_y  <= 32'h0001_0000;
      regs_r.center_x <= '0;
      regs_r.center_y <= '0;
    end else if (wr) begin
      unique case (cfg_paddr)
        ADDR_FOCAL_X:  regs_r.focal_x  <= cfg_pwdata;
        ADDR_FOCAL_Y:  regs_r.focal_y  <= cfg_pwdata;
        ADDR_CENTER_X: regs_r.center_x <= cfg_pwdata;
        ADDR_CENTER_Y: regs_r.center_y <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (cfg_paddr)
      ADDR_FOCAL_X:  cfg_prdata = regs_r.focal_x;
      ADDR_FOCAL_Y:  cfg_prdata = regs_r.focal_y;
      ADDR_CENTER_X: cfg_prdata = regs_r.center_x;
      ADDR_CENTER_Y: cfg_prdata = regs_r.center_y;
      default:       cfg_prdata = '0;
    endcase
  end
endmodule

FILE: sv/ppp_div_stage.sv
module ppp_div_stage
  import ppp_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [5:0]  bit_idx,
  input  logic [31:0] zm,
  input  axis_t       a_in,
  output axis_t       a_out
);
  // one restoring step: rem holds remaining dividend, quotient bit bit_idx decided
  axis_t       nxt;
  logic [95:0] sub;
  logic [95:0] rem_w;

  always_comb begin
    nxt   = a_in;
    rem_w = {32'd0, a_in.rem};
    sub   = {64'd0, zm} << bit_idx;
    if (rem_w >= sub) begin
      nxt.rem          = a_in.rem - sub[63:0];
      nxt.quo[bit_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) a_out <= nxt;
  end
endmodule

FILE: sv/pinhole_point_projection.sv
// pipeline: magnitudes, multiply, 64 divide stages, sign/centre, then saturate and output
// register; one item accepted every cycle while the output is not stalled
// the divider is a 64-stage restoring pipeline, one quotient bit per stage
// stalls freeze the whole pipeline; ready is low only while the output is held
// reset (synchronous, active low) clears valid bits and loads register defaults
module pinhole_point_projection
  import ppp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  ppp_in_if.sink           in_ch,
  ppp_out_if.source        out_ch,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [AddrW-1:0] cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int unsigned NS = DivStages + 4;

  cfg_regs_t regs;
  logic      en;
  logic [NS-1:0] vld_r;

  ppp_cfg u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .regs
  );

  // whole-pipeline enable
  assign en          = !vld_r[NS-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[NS-2:0], in_ch.valid};
  end

  // stage 0: magnitudes and signs
  logic [31:0] xm_r, ym_r, zm0_r, fx_r, fy_r, cx0_r, cy0_r;
  logic        nx_r, ny_r, z0_r;
  always_ff @(posedge clk) begin
    if (en) begin
      xm_r  <= in_ch.point_x[31] ? (~in_ch.point_x + 32'd1) : in_ch.point_x;
      ym_r  <= in_ch.point_y[31] ? (~in_ch.point_y + 32'd1) : in_ch.point_y;
      zm0_r <= in_ch.point_z[31] ? (~in_ch.point_z + 32'd1) : in_ch.point_z;
      nx_r  <= in_ch.point_x[31] ^ in_ch.point_z[31];
      ny_r  <= in_ch.point_y[31] ^ in_ch.point_z[31];
      z0_r  <= (in_ch.point_z == 32'd0);
      fx_r  <= regs.focal_x;
      fy_r  <= regs.focal_y;
      cx0_r <= regs.center_x;
      cy0_r <= regs.center_y;
    end
  end

  // stage 1: exact products
  axis_t ax [DivStages+1];
  axis_t ay [DivStages+1];
  logic [31:0] zm [DivStages+1];
  logic        zz [DivStages+1];
  always_ff @(posedge clk) begin
    if (en) begin
      ax[0].rem <= {32'd0, fx_r} * {32'd0, xm_r};
      ax[0].quo <= '0;
      ax[0].neg <= nx_r;
      ax[0].ctr <= cx0_r;
      ay[0].rem <= {32'd0, fy_r} * {32'd0, ym_r};
      ay[0].quo <= '0;
      ay[0].neg <= ny_r;
      ay[0].ctr <= cy0_r;
      zm[0]     <= zm0_r;
      zz[0]     <= z0_r;
    end
  end

  // divider pipeline, most significant quotient bit first
  for (genvar g = 0; g < DivStages; g++) begin : g_div
    localparam logic [5:0] Bit = 6'(DivStages - 1 - g);
    ppp_div_stage u_dx (.clk, .en, .bit_idx(Bit), .zm(zm[g]), .a_in(ax[g]),
                        .a_out(ax[g+1]));
    ppp_div_stage u_dy (.clk, .en, .bit_idx(Bit), .zm(zm[g]), .a_in(ay[g]),
                        .a_out(ay[g+1]));
    always_ff @(posedge clk) begin
      if (en) begin
        zm[g+1] <= zm[g];
        zz[g+1] <= zz[g];
      end
    end
  end

  // signed sum with centre, 36 bits, large quotients flagged
  logic signed [35:0] su_r, sv_r;
  logic               bu_r, bv_r, nu_r, nv_r, zf_r;
  logic [QW-1:0]      qx, qy;
  assign qx = ax[DivStages].quo;
  assign qy = ay[DivStages].quo;
  always_ff @(posedge clk) begin
    if (en) begin
      bu_r <= (qx[63:34] != '0);
      bv_r <= (qy[63:34] != '0);
      nu_r <= ax[DivStages].neg && (qx != '0);
      nv_r <= ay[DivStages].neg && (qy != '0);
      su_r <= (ax[DivStages].neg ? -$signed({2'b00, qx[33:0]})
                                 :  $signed({2'b00, qx[33:0]}))
              + $signed({4'd0, ax[DivStages].ctr});
      sv_r <= (ay[DivStages].neg ? -$signed({2'b00, qy[33:0]})
                                 :  $signed({2'b00, qy[33:0]}))
              + $signed({4'd0, ay[DivStages].ctr});
      zf_r <= zz[DivStages];
    end
  end

  // saturation and output register
  logic [31:0] u_nxt, v_nxt, u_r, v_r;
  logic        su_sat, sv_sat;
  logic [1:0]  st_nxt, st_r;
  always_comb begin
    su_sat = 1'b1;
    sv_sat = 1'b1;
    if (bu_r) u_nxt = nu_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else if (su_r > 36'sh0_7FFF_FFFF) u_nxt = 32'h7FFF_FFFF;
    else if (su_r < -36'sh0_8000_0000) u_nxt = 32'h8000_0000;
    else begin
      u_nxt = su_r[31:0];
      su_sat = 1'b0;
    end
    if (bv_r) v_nxt = nv_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else if (sv_r > 36'sh0_7FFF_FFFF) v_nxt = 32'h7FFF_FFFF;
    else if (sv_r < -36'sh0_8000_0000) v_nxt = 32'h8000_0000;
    else begin
      v_nxt = sv_r[31:0];
      sv_sat = 1'b0;
    end
    if (zf_r) begin
      u_nxt  = '0;
      v_nxt  = '0;
      st_nxt = ST_ZERO;
    end else begin
      st_nxt = (su_sat || sv_sat) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r  <= u_nxt;
      v_r  <= v_nxt;
      st_r <= st_nxt;
    end
  end

  assign out_ch.valid   = vld_r[NS-1];
  assign out_ch.pixel_u = u_r;
  assign out_ch.pixel_v = v_r;
  assign out_ch.status  = st_r;
endmodule
